[sv/newton_quadratic_root_unit_defines.svh]
// assertion macros for the newton quadratic root unit
`ifndef NEWTON_QUADRATIC_ROOT_UNIT_DEFINES_SVH
`define NEWTON_QUADRATIC_ROOT_UNIT_DEFINES_SVH

// same-cycle implication
`define NQR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NQR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/nqr_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and reset constants of the newton quadratic root unit
package nqr_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int ITER_W      = 8;
  localparam int TOL_W       = 6;
  localparam int STATUS_W    = 2;

  // coefficient reset values, scaled for 32 fraction bits
  localparam int                 RESET_FRAC      = 32;
  localparam logic signed [63:0] RESET_A_Q32     = -64'sd3753801417;
  localparam logic signed [63:0] RESET_B_Q32     = 64'sd7516192768;
  localparam logic signed [63:0] RESET_C_Q32     = 64'sd11282879087;
  localparam logic [ITER_W-1:0]  RESET_MAX_ITER  = 8'd64;
  localparam logic [TOL_W-1:0]   RESET_TOL_SHIFT = 6'd40;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COEF_A    = 3'd0,
    REG_COEF_B    = 3'd1,
    REG_COEF_C    = 3'd2,
    REG_MAX_ITER  = 3'd3,
    REG_TOL_SHIFT = 3'd4
  } cfg_reg_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_CONVERGED  = 2'd0,
    ST_ZERO_DERIV = 2'd1,
    ST_ITER_LIMIT = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_AX_START,
    S_AX_WAIT,
    S_SUM1,
    S_SUM2,
    S_FX_WAIT,
    S_ADD_C,
    S_CHECK,
    S_DIV_WAIT,
    S_UPDATE,
    S_DIFF,
    S_JUDGE,
    S_DONE
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_AX,
    OP_SUM1,
    OP_SUM2,
    OP_ADD_C,
    OP_DIV,
    OP_UPDATE,
    OP_DIFF
  } dp_op_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t  op;
    logic    out_load;
    status_t code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic dv_zero;
    logic ovf;
    logic converged;
    logic limit_hit;
  } stat_t;

endpackage

[sv/nqr_mul.sv]
`timescale 1ns / 1ps
// iterative saturating fixed-point multiplier, one 8-bit digit per cycle
module nqr_mul #(
  parameter int VALUE_WIDTH   = 48,
  parameter int FRACTION_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [VALUE_WIDTH-1:0] op_a,
  input  logic signed [VALUE_WIDTH-1:0] op_b,
  output logic                          done,
  output logic                          ovf,
  output logic signed [VALUE_WIDTH-1:0] prod
);

  localparam int W   = VALUE_WIDTH;
  localparam int F   = FRACTION_BITS;
  localparam int DIG = 8;
  localparam int ND  = (W + DIG - 1) / DIG;
  localparam int BW  = ND * DIG;
  localparam int AW  = BW + W;
  localparam int CW  = $clog2(ND + 1);

  localparam logic [AW-1:0] HALF = {{(AW-1){1'b0}}, 1'b1} << (W - 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  mag_a_r;
  logic [BW-1:0] mag_b_r;
  logic          neg_r;
  logic [AW-1:0] acc_r;
  logic [W-1:0]  prod_r;
  logic          ovf_r;

  logic [W-1:0]     mag_a;
  logic [W-1:0]     mag_b;
  logic [W+DIG-1:0] part;
  logic [AW-1:0]    acc_nxt;
  logic [AW-1:0]    shifted;
  logic [AW-1:0]    lim;
  logic             sat;
  logic [W-1:0]     mag_res;

  // operand magnitudes
  always_comb begin
    mag_a = op_a[W-1] ? W'(-op_a) : W'(op_a);
    mag_b = op_b[W-1] ? W'(-op_b) : W'(op_b);
  end

  // one digit of b per cycle, most significant first
  always_comb begin
    part    = mag_a_r * mag_b_r[BW-1 -: DIG];
    acc_nxt = (acc_r << DIG) + AW'(part);
  end

  // drop fraction bits and saturate
  always_comb begin
    shifted = acc_r >> F;
    lim     = neg_r ? HALF : HALF - 1'b1;
    sat     = shifted > lim;
    mag_res = sat ? lim[W-1:0] : shifted[W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(ND);
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end else begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // operands, accumulator and result
  always_ff @(posedge clk) begin
    if (start) begin
      mag_a_r <= mag_a;
      mag_b_r <= BW'(mag_b);
      neg_r   <= op_a[W-1] ^ op_b[W-1];
      acc_r   <= '0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        acc_r   <= acc_nxt;
        mag_b_r <= mag_b_r << DIG;
      end else begin
        prod_r <= neg_r ? W'(-mag_res) : mag_res;
        ovf_r  <= sat;
      end
    end
  end

  assign done = done_r;
  assign ovf  = ovf_r;
  assign prod = prod_r;

endmodule

[sv/nqr_div.sv]
`timescale 1ns / 1ps
// restoring saturating fixed-point divider, one quotient bit per cycle
module nqr_div #(
  parameter int VALUE_WIDTH   = 48,
  parameter int FRACTION_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [VALUE_WIDTH-1:0] num,
  input  logic signed [VALUE_WIDTH-1:0] den,
  output logic                          done,
  output logic                          ovf,
  output logic signed [VALUE_WIDTH-1:0] quo
);

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int NB = W + F;
  localparam int CW = $clog2(NB + 1);

  localparam logic [NB-1:0] HALF = {{(NB-1){1'b0}}, 1'b1} << (W - 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NB-1:0] n_r;
  logic [W-1:0]  dm_r;
  logic [W-1:0]  r_r;
  logic [NB-1:0] q_r;
  logic          neg_r;
  logic [W-1:0]  quo_r;
  logic          ovf_r;

  logic [W-1:0]  mag_n;
  logic [W-1:0]  mag_d;
  logic [W:0]    rs;
  logic          ge;
  logic [W:0]    r_sub;
  logic [NB-1:0] lim;
  logic          sat;
  logic [W-1:0]  mag_res;

  // operand magnitudes
  always_comb begin
    mag_n = num[W-1] ? W'(-num) : W'(num);
    mag_d = den[W-1] ? W'(-den) : W'(den);
  end

  // trial subtract
  always_comb begin
    rs    = {r_r, n_r[NB-1]};
    ge    = rs >= {1'b0, dm_r};
    r_sub = rs - {1'b0, dm_r};
  end

  // saturate the quotient magnitude
  always_comb begin
    lim     = neg_r ? HALF : HALF - 1'b1;
    sat     = q_r > lim;
    mag_res = sat ? lim[W-1:0] : q_r[W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(NB);
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end else begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // remainder, quotient and result
  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= NB'(mag_n) << F;
      dm_r  <= mag_d;
      r_r   <= '0;
      q_r   <= '0;
      neg_r <= num[W-1] ^ den[W-1];
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        r_r <= ge ? r_sub[W-1:0] : rs[W-1:0];
        q_r <= {q_r[NB-2:0], ge};
        n_r <= n_r << 1;
      end else begin
        quo_r <= neg_r ? W'(-mag_res) : mag_res;
        ovf_r <= sat;
      end
    end
  end

  assign done = done_r;
  assign ovf  = ovf_r;
  assign quo  = quo_r;

endmodule

[sv/nqr_datapath.sv]
`timescale 1ns / 1ps
// estimate registers, saturating adders, a shared multiplier and a divider
module nqr_datapath #(
  parameter int VALUE_WIDTH   = 48,
  parameter int FRACTION_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nqr_pkg::cmd_t                       cmd,
  input  logic signed [VALUE_WIDTH-1:0]       coef_a,
  input  logic signed [VALUE_WIDTH-1:0]       coef_b,
  input  logic signed [VALUE_WIDTH-1:0]       coef_c,
  input  logic [nqr_pkg::ITER_W-1:0]          max_iter,
  input  logic [nqr_pkg::TOL_W-1:0]           tol_shift,
  input  logic signed [VALUE_WIDTH-1:0]       start_value,
  output nqr_pkg::stat_t                      stat,
  output logic signed [VALUE_WIDTH-1:0]       root,
  output logic [nqr_pkg::ITER_W-1:0]          iterations,
  output nqr_pkg::status_t                    status
);

  import nqr_pkg::*;

  localparam int W = VALUE_WIDTH;

  localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};

  logic [W-1:0]      x_r;
  logic [W-1:0]      xold_r;
  logic [W-1:0]      t_r;
  logic [W-1:0]      dv_r;
  logic [W-1:0]      fv_r;
  logic [W-1:0]      diff_r;
  logic [W-1:0]      lim_r;
  logic [ITER_W-1:0] steps_r;
  logic              ovf_r;
  logic [W-1:0]      root_r;
  logic [ITER_W-1:0] iter_r;
  status_t           status_r;

  logic         mul_start;
  logic [W-1:0] mul_opa;
  logic         mul_done;
  logic         mul_ovf;
  logic [W-1:0] mul_prod;
  logic         div_start;
  logic         div_done;
  logic         div_ovf;
  logic [W-1:0] div_quo;

  logic [W:0]   sum_ab;
  logic [W:0]   sum_aa;
  logic [W:0]   sum_db;
  logic [W:0]   sum_c;
  logic [W:0]   sub_x;
  logic [W:0]   diff_w;
  logic [W-1:0] diff_abs;
  logic [W-1:0] mag_x;

  // saturating add, overflow flag in the top bit
  function automatic logic [W:0] sat_add(input logic [W-1:0] p, input logic [W-1:0] q);
    logic [W:0] s;
    logic [W:0] res;
    s = {p[W-1], p} + {q[W-1], q};
    if (s[W] != s[W-1]) res = {1'b1, (s[W] ? MIN_V : MAX_V)};
    else res = {1'b0, s[W-1:0]};
    return res;
  endfunction

  // saturating subtract, overflow flag in the top bit
  function automatic logic [W:0] sat_sub(input logic [W-1:0] p, input logic [W-1:0] q);
    logic [W:0] s;
    logic [W:0] res;
    s = {p[W-1], p} - {q[W-1], q};
    if (s[W] != s[W-1]) res = {1'b1, (s[W] ? MIN_V : MAX_V)};
    else res = {1'b0, s[W-1:0]};
    return res;
  endfunction

  // multiplier: a*x, then (a*x+b)*x
  assign mul_start = (cmd.op == OP_MUL_AX) || (cmd.op == OP_SUM2);
  assign mul_opa   = (cmd.op == OP_MUL_AX) ? W'(coef_a) : t_r;

  nqr_mul #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .op_a (mul_opa),
    .op_b (x_r),
    .done (mul_done),
    .ovf  (mul_ovf),
    .prod (mul_prod)
  );

  // divider: f / f'
  assign div_start = (cmd.op == OP_DIV);

  nqr_div #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (fv_r),
    .den  (dv_r),
    .done (div_done),
    .ovf  (div_ovf),
    .quo  (div_quo)
  );

  // adders
  always_comb begin
    sum_ab = sat_add(mul_prod, W'(coef_b));
    sum_aa = sat_add(mul_prod, mul_prod);
    sum_db = sat_add(dv_r, W'(coef_b));
    sum_c  = sat_add(mul_prod, W'(coef_c));
    sub_x  = sat_sub(x_r, div_quo);
  end

  // step size and scaled estimate for the convergence test
  always_comb begin
    diff_w   = {x_r[W-1], x_r} - {xold_r[W-1], xold_r};
    diff_abs = diff_w[W] ? W'(-diff_w) : diff_w[W-1:0];
    mag_x    = x_r[W-1] ? W'(-x_r) : x_r;
  end

  // step count and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          steps_r <= '0;
        end
        OP_MUL_AX: begin
          ovf_r <= 1'b0;
        end
        OP_SUM1: begin
          ovf_r <= ovf_r | mul_ovf | sum_ab[W] | sum_aa[W];
        end
        OP_SUM2: begin
          ovf_r <= ovf_r | sum_db[W];
        end
        OP_ADD_C: begin
          ovf_r <= ovf_r | mul_ovf | sum_c[W];
        end
        OP_UPDATE: begin
          steps_r <= steps_r + 1'b1;
          ovf_r   <= ovf_r | div_ovf | sub_x[W];
        end
        default: begin
        end
      endcase
    end
  end

  // working values
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x_r <= start_value;
      end
      OP_SUM1: begin
        t_r  <= sum_ab[W-1:0];
        dv_r <= sum_aa[W-1:0];
      end
      OP_SUM2: begin
        dv_r <= sum_db[W-1:0];
      end
      OP_ADD_C: begin
        fv_r <= sum_c[W-1:0];
      end
      OP_UPDATE: begin
        xold_r <= x_r;
        x_r    <= sub_x[W-1:0];
      end
      OP_DIFF: begin
        diff_r <= diff_abs;
        lim_r  <= mag_x >> tol_shift;
      end
      default: begin
      end
    endcase
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      root_r   <= x_r;
      iter_r   <= steps_r;
      status_r <= cmd.code;
    end
  end

  // status toward the controller
  always_comb begin
    stat.mul_done  = mul_done;
    stat.div_done  = div_done;
    stat.dv_zero   = (dv_r == '0);
    stat.ovf       = ovf_r;
    stat.converged = (diff_r <= lim_r);
    stat.limit_hit = (steps_r >= max_iter);
  end

  assign root       = root_r;
  assign iterations = iter_r;
  assign status     = status_r;

endmodule

[sv/nqr_ctrl.sv]
`timescale 1ns / 1ps
// sequencer for one newton step at a time and the output word handshake
module nqr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           out_stall,
  output logic           out_valid,
  input  nqr_pkg::stat_t stat,
  output nqr_pkg::cmd_t  cmd
);

  import nqr_pkg::*;

  state_t  state_r;
  state_t  state_nxt;
  status_t code_r;
  status_t code_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    out_free;

  // output register can take a word this cycle
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_AX_START;
      end
      S_AX_START: begin
        state_nxt = S_AX_WAIT;
      end
      S_AX_WAIT: begin
        if (stat.mul_done) state_nxt = S_SUM1;
      end
      S_SUM1: begin
        state_nxt = S_SUM2;
      end
      S_SUM2: begin
        state_nxt = S_FX_WAIT;
      end
      S_FX_WAIT: begin
        if (stat.mul_done) state_nxt = S_ADD_C;
      end
      S_ADD_C: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.dv_zero) begin
          code_nxt  = ST_ZERO_DERIV;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (stat.div_done) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        state_nxt = S_JUDGE;
      end
      S_JUDGE: begin
        if (stat.ovf) begin
          code_nxt  = ST_OVERFLOW;
          state_nxt = S_DONE;
        end else if (stat.converged) begin
          code_nxt  = ST_CONVERGED;
          state_nxt = S_DONE;
        end else if (stat.limit_hit) begin
          code_nxt  = ST_ITER_LIMIT;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_AX_START;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall     = 1'b1;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    cmd.code     = code_r;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_AX_START: cmd.op = OP_MUL_AX;
      S_SUM1:     cmd.op = OP_SUM1;
      S_SUM2:     cmd.op = OP_SUM2;
      S_ADD_C:    cmd.op = OP_ADD_C;
      S_CHECK: begin
        if (!stat.dv_zero) cmd.op = OP_DIV;
      end
      S_UPDATE:   cmd.op = OP_UPDATE;
      S_DIFF:     cmd.op = OP_DIFF;
      S_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_r      <= ST_CONVERGED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[sv/newton_quadratic_root_unit.sv]
// Newton-Raphson root finder for a*x*x + b*x + c in signed fixed point.
// Input channel (in_valid, in_stall, in_start_value) takes a start estimate;
// the result channel (out_valid, out_stall) returns one word per estimate:
// root, Newton step count and status (converged, zero derivative,
// iteration limit, overflow). Coefficients, iteration limit and tolerance
// shift are written through cfg_valid/cfg_ready/cfg_index/cfg_data; the
// user must write them only while no estimate is in flight, which the
// block does not enforce; cfg_ready is always high. One estimate is
// worked at a time. Each Newton step uses the 8-bit-per-cycle multiplier
// twice and the one-bit-per-cycle divider once. The next estimate can be
// accepted in the cycle after the result word is loaded.
// A finished word waits in the output register while the next estimate is
// accepted; if the receiver stalls, the engine holds its next result until
// the register frees. Synchronous active-low reset empties the pipeline and
// restores the default coefficients, limit 64 and tolerance shift 40.
`timescale 1ns / 1ps
`include "newton_quadratic_root_unit_defines.svh"
// top level: configuration registers, controller and datapath
module newton_quadratic_root_unit #(
  parameter int VALUE_WIDTH   = 48,
  parameter int FRACTION_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [VALUE_WIDTH-1:0]        in_start_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [VALUE_WIDTH-1:0]        out_root,
  output logic [nqr_pkg::ITER_W-1:0]           out_iterations,
  output logic [nqr_pkg::STATUS_W-1:0]         out_status,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nqr_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [VALUE_WIDTH-1:0]               cfg_data
);

  import nqr_pkg::*;

  // reset coefficients rescaled to the fraction width
  localparam int SCALE_UP = (FRACTION_BITS > RESET_FRAC) ? FRACTION_BITS - RESET_FRAC : 0;
  localparam int SCALE_DN = (FRACTION_BITS < RESET_FRAC) ? RESET_FRAC - FRACTION_BITS : 0;
  localparam logic signed [63:0] A_SCALED = (RESET_A_Q32 <<< SCALE_UP) >>> SCALE_DN;
  localparam logic signed [63:0] B_SCALED = (RESET_B_Q32 <<< SCALE_UP) >>> SCALE_DN;
  localparam logic signed [63:0] C_SCALED = (RESET_C_Q32 <<< SCALE_UP) >>> SCALE_DN;
  localparam logic [VALUE_WIDTH-1:0] RESET_A_V = A_SCALED[VALUE_WIDTH-1:0];
  localparam logic [VALUE_WIDTH-1:0] RESET_B_V = B_SCALED[VALUE_WIDTH-1:0];
  localparam logic [VALUE_WIDTH-1:0] RESET_C_V = C_SCALED[VALUE_WIDTH-1:0];

  logic [VALUE_WIDTH-1:0] coef_a_r;
  logic [VALUE_WIDTH-1:0] coef_b_r;
  logic [VALUE_WIDTH-1:0] coef_c_r;
  logic [ITER_W-1:0]      max_iter_r;
  logic [TOL_W-1:0]       tol_shift_r;

  cmd_t    cmd;
  stat_t   stat;
  status_t status;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r    <= RESET_A_V;
      coef_b_r    <= RESET_B_V;
      coef_c_r    <= RESET_C_V;
      max_iter_r  <= RESET_MAX_ITER;
      tol_shift_r <= RESET_TOL_SHIFT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COEF_A:    coef_a_r    <= cfg_data;
        REG_COEF_B:    coef_b_r    <= cfg_data;
        REG_COEF_C:    coef_c_r    <= cfg_data;
        REG_MAX_ITER:  max_iter_r  <= cfg_data[ITER_W-1:0];
        REG_TOL_SHIFT: tol_shift_r <= cfg_data[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  nqr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic
  nqr_datapath #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .coef_a     (coef_a_r),
    .coef_b     (coef_b_r),
    .coef_c     (coef_c_r),
    .max_iter   (max_iter_r),
    .tol_shift  (tol_shift_r),
    .start_value(in_start_value),
    .stat       (stat),
    .root       (out_root),
    .iterations (out_iterations),
    .status     (status)
  );

  assign out_status = status;

  // checks
  `NQR_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall,
                  "input taken while an estimate is in work")
  `NQR_ASSERT_NXT(a_no_early_result, clk, rst_n, in_valid && !in_stall, !$rose(out_valid),
                  "result word appeared right after acceptance")
  `NQR_ASSERT_IMP(a_steps_taken, clk, rst_n,
                  out_valid && (out_status != ST_ZERO_DERIV), out_iterations != '0,
                  "result without a newton step")

endmodule
